// ===== design/mtp_pkg.sv =====
// Package with the shared constants, types and word functions of the MT19937 generator.
`default_nettype none
package mtp_pkg;

  localparam int WORD_W = 32;
  localparam int MT_WORDS = 624;
  localparam int MT_SHIFT = 397;
  localparam int IDX_W = $clog2(MT_WORDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam word_t MT_INIT_MULT = 32'd1812433253;
  localparam word_t MT_MATRIX = 32'h9908_B0DF;
  localparam word_t MT_TEMPER_B = 32'h9D2C_5680;
  localparam word_t MT_TEMPER_C = 32'hEFC6_0000;
  localparam word_t MT_UPPER = 32'h8000_0000;
  localparam word_t MT_LOWER = 32'h7FFF_FFFF;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  // Shift control of the state chain.
  typedef struct packed {
    logic  shift;
    word_t din;
  } chain_ctrl_t;

  // Fixed taps of the state chain.
  typedef struct packed {
    word_t head;
    word_t next;
    word_t far;
    word_t tail;
  } chain_taps_t;

  // Output of the reseed sequencer.
  typedef struct packed {
    logic  active;
    word_t word;
  } seed_fill_t;

  function automatic word_t mtp_twist(input word_t head, input word_t next, input word_t far);
    word_t y;
    word_t w;
    y = (head & MT_UPPER) | (next & MT_LOWER);
    w = far ^ (y >> 1);
    if (y[0]) begin
      w = w ^ MT_MATRIX;
    end
    return w;
  endfunction

  function automatic word_t mtp_temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== design/mtp_cell.sv =====
// One cell of the state chain: a single state word loaded from its neighbor on a shift.
`default_nettype none
module mtp_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          shift,
  input  wire mtp_pkg::word_t din,
  output mtp_pkg::word_t     dout
);
  import mtp_pkg::*;

  word_t word;

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (shift) begin
      word <= din;
    end
  end

  assign dout = word;

endmodule
`default_nettype wire

// ===== design/mtp_chain.sv =====
// The state chain: a row of cells that moves every word one place toward the head on a shift.
`default_nettype none
module mtp_chain (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mtp_pkg::chain_ctrl_t ctrl,
  output mtp_pkg::chain_taps_t      taps
);
  import mtp_pkg::*;

  word_t words [MT_WORDS];

  for (genvar k = 0; k < MT_WORDS; k++) begin : g_cell
    word_t cell_in;
    if (k == MT_WORDS - 1) begin : g_tail
      assign cell_in = ctrl.din;
    end else begin : g_body
      assign cell_in = words[k+1];
    end
    mtp_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctrl.shift),
      .din   (cell_in),
      .dout  (words[k])
    );
  end

  // The head holds the word at the current draw index.
  assign taps.head = words[0];
  assign taps.next = words[1];
  assign taps.far  = words[MT_SHIFT];
  assign taps.tail = words[MT_WORDS-1];

endmodule
`default_nettype wire

// ===== design/mtp_seed.sv =====
// Reseed sequencer: produces the seed recurrence words, one per cycle, after the seed itself.
`default_nettype none
module mtp_seed (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire mtp_pkg::word_t  tail,
  output mtp_pkg::seed_fill_t  fill
);
  import mtp_pkg::*;

  logic  active;
  idx_t  count;
  word_t mixed;
  word_t product;

  assign mixed   = tail ^ (tail >> 30);
  assign product = MT_INIT_MULT * mixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
    end else if (start) begin
      active <= 1'b1;
      count  <= idx_t'(1);
    end else if (active) begin
      count <= count + idx_t'(1);
      if (count == idx_t'(MT_WORDS - 1)) begin
        active <= 1'b0;
      end
    end
  end

  assign fill.active = active;
  assign fill.word   = product + word_t'(count);

endmodule
`default_nettype wire

// ===== design/mersenne_twister_prng.sv =====
// Top level of the MT19937 random generator with a shift-chain state and a registered output.
//
//  Channel  Handshake              Payload                 Direction
//  -------  ---------------------  ----------------------  ---------
//  in       in_valid / in_ready    command, seed_value     into block
//  out      out_valid / out_ready  random_value (31 bits)  out of block
//
// In a draw, the twist of the head word and its tempering are done in the
// accept cycle, and the result lands in the output register. Draws can be
// transferred back to back, one per cycle, as long as the output is taken.
// In a reseed, the seed is shifted in on its transfer cycle and the
// remaining 623 words come from the one multiplier of the seed recurrence, one per
// cycle, while in_ready stays low. Reset clears every state word to zero and the
// output register to empty. A stalled output holds its value, and in_ready then
// stays low for every command.
`default_nettype none
module mersenne_twister_prng (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [31:0] seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      random_value
);
  import mtp_pkg::*;

  chain_ctrl_t ctrl;
  chain_taps_t taps;
  seed_fill_t  fill;
  logic        in_xfer;
  logic        draw_xfer;
  logic        seed_xfer;
  word_t       twisted;
  word_t       tempered;

  // The state chain is a shift line of 624 words. The head cell always holds
  // the word at the current draw index, so the draw index itself is implicit:
  // each draw twists the head with its neighbor and the word 397 places on, and
  // shifts the new word in at the tail.
  mtp_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .taps (taps)
  );

  // The reseed sequencer feeds back on the tail, which always holds the word
  // most recently shifted in.
  mtp_seed u_seed (
    .clk   (clk),
    .rst   (rst),
    .start (seed_xfer),
    .tail  (taps.tail),
    .fill  (fill)
  );

  // Input is taken whenever no reseed is running and the output register is
  // either empty or being emptied in this cycle.
  assign in_ready  = !fill.active && (!out_valid || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign draw_xfer = in_xfer && (command == CMD_DRAW);
  assign seed_xfer = in_xfer && (command == CMD_RESEED);

  assign twisted  = mtp_twist(taps.head, taps.next, taps.far);
  assign tempered = mtp_temper(twisted);

  always_comb begin
    ctrl.shift = in_xfer || fill.active;
    if (fill.active) begin
      ctrl.din = fill.word;
    end else if (command == CMD_RESEED) begin
      ctrl.din = seed_value;
    end else begin
      ctrl.din = twisted;
    end
  end

  // Output register: set by a draw, cleared when the result is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (draw_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_xfer) begin
      random_value <= tempered[30:0];
    end
  end

  // A reseed that is running never overlaps an input transfer.
  a_no_input_while_seeding: assert property (@(posedge clk) disable iff (rst)
    fill.active |-> !in_ready)
    else $error("input taken while the state is being reseeded");

  // A reseed transfer starts the fill sequence and makes no result.
  a_reseed_starts_fill: assert property (@(posedge clk) disable iff (rst)
    seed_xfer |=> (fill.active && !(out_valid && !$past(out_valid))))
    else $error("reseed did not start the fill or produced a result");

  // Every draw transfer leaves a result in the output register.
  a_draw_gives_result: assert property (@(posedge clk) disable iff (rst)
    draw_xfer |=> out_valid)
    else $error("draw transfer produced no result");

endmodule
`default_nettype wire
